>>> rtl/hsvrgb_pkg.sv
// Shared types and fixed constants for the HSV/HSL to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    typedef enum logic [0:0] {
        MODEL_HSV = 1'b0,
        MODEL_HSL = 1'b1
    } colour_model_t;

    localparam int unsigned Y_W         = 12;
    localparam int unsigned DIV15_W     = 16;
    localparam int unsigned DIV15_SHIFT = 19;
    localparam int unsigned PROD_W      = Y_W + DIV15_W;
    localparam int unsigned Q_W         = PROD_W - DIV15_SHIFT;

    localparam logic [DIV15_W-1:0] DIV15_MUL = 16'd34953;
    localparam logic [Q_W-1:0]     BYTE_MAX  = 9'd255;

    localparam int unsigned SECTORS = 6;

endpackage : hsvrgb_pkg

`default_nettype wire

>>> rtl/hsv_hsl_to_rgb_unit.sv
// Six-stage pipelined HSV/HSL to 8-bit RGB colour converter.
// Each accepted input word is registered through stages 1 to 6 in turn.
// Throughput: one word per cycle while out_stall is low; each stage holds one word and a free stage
// takes the next word while a later stage stalls.
// Reset clears every stage valid bit and sets the colour model to HSV.
`default_nettype none

module hsv_hsl_to_rgb_unit #(
    parameter int unsigned HUE_FRAC_BITS  = 6,
    parameter int unsigned UNIT_FRAC_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [HUE_FRAC_BITS+8:0]    hue,
    input  logic [UNIT_FRAC_BITS:0]     saturation_in,
    input  logic [UNIT_FRAC_BITS:0]     level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);

    import hsvrgb_pkg::*;

    localparam int unsigned HF   = HUE_FRAC_BITS;
    localparam int unsigned UF   = UNIT_FRAC_BITS;
    localparam int unsigned HW   = HF + 9;
    localparam int unsigned HI_W = HW - HF;
    localparam int unsigned UW   = UF + 1;
    localparam int unsigned XW   = HF + 6;
    localparam int unsigned CW   = 2 * UF + 1;
    localparam int unsigned NW   = HF + 7 + 2 * UF;
    localparam int unsigned ZW   = NW + 9;
    localparam int unsigned K    = 4 + HF + 2 * UF;

    localparam int unsigned H6       = 60 << HF;
    localparam int unsigned UNIT_ONE = 1 << UF;

    localparam logic [HW-1:0] HUE_MAX  = HW'(360 << HF);
    localparam logic [UW-1:0] UNIT_MAX = UW'(UNIT_ONE);
    localparam logic [ZW-1:0] DEN_Z    = ZW'(2 * H6) << (2 * UF);

    colour_model_t colour_model_reg;

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // stage 1
    logic [2:0]      sector1_reg, sector1_next;
    logic [XW-1:0]   xw1_reg, xw1_next;
    logic [UW-1:0]   a1_reg, a1_next;
    logic [UW-1:0]   s1_reg, s1_next;
    logic [UW-1:0]   l1_reg, l1_next;
    colour_model_t   model1_reg;

    // stage 2
    logic [2:0]      sector2_reg;
    logic [XW-1:0]   xw2_reg;
    logic [UW-1:0]   l2_reg;
    logic [CW-1:0]   cnum2_reg, cnum2_next;
    colour_model_t   model2_reg;

    // stage 3
    logic [2:0]      sector3_reg;
    logic [NW-1:0]   cc3_reg, cc3_next;
    logic [NW-1:0]   xx3_reg, xx3_next;
    logic [NW-1:0]   m3_reg, m3_next;

    // stage 4, 5, 6
    logic [NW-1:0]   num4_reg [3];
    logic [NW-1:0]   num4_next [3];
    logic [Y_W-1:0]  y5_reg [3];
    logic [Y_W-1:0]  y5_next [3];
    logic [7:0]      byte6_reg [3];
    logic [7:0]      byte6_next [3];

    assign rdy6 = !v6_reg || !out_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = !rdy1;
    assign out_valid = v6_reg;
    assign red       = byte6_reg[0];
    assign green     = byte6_reg[1];
    assign blue      = byte6_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_model_reg <= MODEL_HSV;
        end
        else if (cfg_we)
        begin
            colour_model_reg <= colour_model_t'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // stage 1: clamp, hue sector, position in sector, chroma factor
    always_comb
    begin
        logic [HW-1:0]   h_c;
        logic [HI_W-1:0] hi;
        logic [HW-1:0]   r_full;
        logic [XW-1:0]   r;
        logic [UW:0]     two_l;
        logic [UW:0]     l_dist;
        logic [UW-1:0]   l_c;

        h_c   = (hue > HUE_MAX) ? HUE_MAX : hue;
        s1_next = (saturation_in > UNIT_MAX) ? UNIT_MAX : saturation_in;
        l_c   = (level > UNIT_MAX) ? UNIT_MAX : level;
        l1_next = l_c;

        hi = h_c[HW-1:HF];
        sector1_next = 3'd0;
        for (int i = 1; i <= SECTORS; i++)
        begin
            if (hi >= HI_W'(60 * i))
            begin
                sector1_next = sector1_next + 3'd1;
            end
        end

        r_full = h_c - HW'(sector1_next) * HW'(H6);
        r      = r_full[XW-1:0];
        xw1_next = sector1_next[0] ? (XW'(H6) - r) : r;

        two_l = {l_c, 1'b0};
        l_dist = (two_l >= (UW+1)'(UNIT_ONE)) ? (two_l - (UW+1)'(UNIT_ONE))
                                              : ((UW+1)'(UNIT_ONE) - two_l);
        if (colour_model_reg == MODEL_HSL)
        begin
            a1_next = UW'((UW+1)'(UNIT_ONE) - l_dist);
        end
        else
        begin
            a1_next = l_c;
        end
    end

    // stage 2: chroma product
    assign cnum2_next = CW'(a1_reg) * CW'(s1_reg);

    // stage 3: chroma, second component and offset over the common scale
    always_comb
    begin
        logic [NW-1:0] lu;
        logic [NW-1:0] cn;

        lu = NW'(l2_reg) << UF;
        cn = NW'(cnum2_reg);
        cc3_next = cn * NW'(2 * H6);
        xx3_next = cn * NW'({xw2_reg, 1'b0});
        if (model2_reg == MODEL_HSL)
        begin
            m3_next = ((lu << 1) - cn) * NW'(H6);
        end
        else
        begin
            m3_next = (lu - cn) * NW'(2 * H6);
        end
    end

    // stage 4: place components by sector and add the offset
    always_comb
    begin
        logic [NW-1:0] ch [3];

        ch[0] = '0;
        ch[1] = '0;
        ch[2] = '0;
        unique case (sector3_reg)
            3'd1:
            begin
                ch[0] = xx3_reg;
                ch[1] = cc3_reg;
            end
            3'd2:
            begin
                ch[1] = cc3_reg;
                ch[2] = xx3_reg;
            end
            3'd3:
            begin
                ch[1] = xx3_reg;
                ch[2] = cc3_reg;
            end
            3'd4:
            begin
                ch[2] = cc3_reg;
                ch[0] = xx3_reg;
            end
            3'd5:
            begin
                ch[2] = xx3_reg;
                ch[0] = cc3_reg;
            end
            default:
            begin
                ch[0] = cc3_reg;
                ch[1] = xx3_reg;
            end
        endcase
        for (int c = 0; c < 3; c++)
        begin
            num4_next[c] = ch[c] + m3_reg;
        end
    end

    // stage 5: scale by 510, add rounding term, drop the power-of-two part
    always_comb
    begin
        logic [ZW-1:0] z [3];

        for (int c = 0; c < 3; c++)
        begin
            z[c] = (ZW'(num4_reg[c]) << 9) - (ZW'(num4_reg[c]) << 1) + DEN_Z;
            y5_next[c] = z[c][K +: Y_W];
        end
    end

    // stage 6: divide by fifteen and saturate
    always_comb
    begin
        logic [PROD_W-1:0] p [3];
        logic [Q_W-1:0]    q [3];

        for (int c = 0; c < 3; c++)
        begin
            p[c] = PROD_W'(y5_reg[c]) * PROD_W'(DIV15_MUL);
            q[c] = p[c][DIV15_SHIFT +: Q_W];
            byte6_next[c] = (q[c] > BYTE_MAX) ? 8'hFF : q[c][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            sector1_reg <= sector1_next;
            xw1_reg     <= xw1_next;
            a1_reg      <= a1_next;
            s1_reg      <= s1_next;
            l1_reg      <= l1_next;
            model1_reg  <= colour_model_reg;
        end
        if (rdy2 && v1_reg)
        begin
            sector2_reg <= sector1_reg;
            xw2_reg     <= xw1_reg;
            l2_reg      <= l1_reg;
            cnum2_reg   <= cnum2_next;
            model2_reg  <= model1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sector3_reg <= sector2_reg;
            cc3_reg     <= cc3_next;
            xx3_reg     <= xx3_next;
            m3_reg      <= m3_next;
        end
        if (rdy4 && v3_reg)
        begin
            num4_reg <= num4_next;
        end
        if (rdy5 && v4_reg)
        begin
            y5_reg <= y5_next;
        end
        if (rdy6 && v5_reg)
        begin
            byte6_reg <= byte6_next;
        end
    end

endmodule : hsv_hsl_to_rgb_unit

`default_nettype wire

>>> tb/hsv_hsl_to_rgb_unit_tb.sv
// Self-checking testbench for the HSV/HSL to RGB converter under random flow control.
`default_nettype none

module hsv_hsl_to_rgb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    localparam int unsigned HUE_FRAC    = 6;
    localparam int unsigned UNIT_FRAC   = 12;
    localparam int unsigned HUE_W       = HUE_FRAC + 9;
    localparam int unsigned UNIT_W      = UNIT_FRAC + 1;
    localparam longint unsigned HUE_SIXTY = 64'd60 << HUE_FRAC;
    localparam longint unsigned HUE_MAX   = 64'd360 << HUE_FRAC;
    localparam longint unsigned UNIT_ONE  = 64'd1 << UNIT_FRAC;
    localparam int unsigned STALL_LIMIT = 4000;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [UNIT_W-1:0] sat;
        logic [UNIT_W-1:0] lvl;
    } colour_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic              cfg_wdata     = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic [HUE_W-1:0]  hue           = '0;
    logic [UNIT_W-1:0] saturation_in = '0;
    logic [UNIT_W-1:0] level         = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;

    colour_in_t    pending_colours [$];
    rgb_t          rgb_expected [$];
    rgb_t          rgb_want;
    colour_model_t active_model = MODEL_HSV;

    logic in_fire      = 1'b0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   hold_left    = 0;
    int   next_hold_at = 90;
    int   pattern_mode = 0;
    int   pattern_left = 0;
    logic pattern_tick = 1'b0;
    int   results_seen = 0;
    int   error_count  = 0;
    int   idle_cycles  = 0;

    hsv_hsl_to_rgb_unit #(
        .HUE_FRAC_BITS  (HUE_FRAC),
        .UNIT_FRAC_BITS (UNIT_FRAC)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .hue           (hue),
        .saturation_in (saturation_in),
        .level         (level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue)
    );

    function automatic rgb_t convert_colour(input logic [HUE_W-1:0] h_in,
                                            input logic [UNIT_W-1:0] s_in,
                                            input logic [UNIT_W-1:0] l_in,
                                            input colour_model_t model);
        longint unsigned h, s, l, l_dist, cnum, cc, xx, m, f, t, sector, den, q;
        longint unsigned chan [3];
        logic [7:0]      byte_val [3];
        rgb_t            res;
        h = 64'(h_in);
        s = 64'(s_in);
        l = 64'(l_in);
        if (h > HUE_MAX)
            h = HUE_MAX;
        if (s > UNIT_ONE)
            s = UNIT_ONE;
        if (l > UNIT_ONE)
            l = UNIT_ONE;
        den = 2 * HUE_SIXTY * UNIT_ONE * UNIT_ONE;
        if (model == MODEL_HSV)
            cnum = l * s;
        else
        begin
            l_dist = (2 * l >= UNIT_ONE) ? 2 * l - UNIT_ONE : UNIT_ONE - 2 * l;
            cnum = (UNIT_ONE - l_dist) * s;
        end
        f  = h % (2 * HUE_SIXTY);
        t  = (f >= HUE_SIXTY) ? f - HUE_SIXTY : HUE_SIXTY - f;
        cc = cnum * 2 * HUE_SIXTY;
        xx = cnum * 2 * (HUE_SIXTY - t);
        if (model == MODEL_HSV)
            m = l * UNIT_ONE * 2 * HUE_SIXTY - cc;
        else
            m = l * UNIT_ONE * 2 * HUE_SIXTY - cnum * HUE_SIXTY;
        chan[0] = 0;
        chan[1] = 0;
        chan[2] = 0;
        sector = h / HUE_SIXTY;
        case (sector)
            1:
            begin
                chan[0] = xx;
                chan[1] = cc;
            end
            2:
            begin
                chan[1] = cc;
                chan[2] = xx;
            end
            3:
            begin
                chan[1] = xx;
                chan[2] = cc;
            end
            4:
            begin
                chan[2] = cc;
                chan[0] = xx;
            end
            5:
            begin
                chan[2] = xx;
                chan[0] = cc;
            end
            default:
            begin
                chan[0] = cc;
                chan[1] = xx;
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            q = (510 * (chan[i] + m) + den) / (2 * den);
            byte_val[i] = (q > 255) ? 8'd255 : q[7:0];
        end
        res.red   = byte_val[0];
        res.green = byte_val[1];
        res.blue  = byte_val[2];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: bursts and gaps; hold a stalled word.
    always @(negedge clk)
    begin
        if (in_valid && !in_fire)
        begin
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_colours.size() != 0)
        begin
            in_valid      <= 1'b1;
            hue           <= pending_colours[0].hue;
            saturation_in <= pending_colours[0].sat;
            level         <= pending_colours[0].lvl;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: long hold-offs at set result counts, otherwise a changing pattern.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (results_seen >= next_hold_at)
        begin
            out_stall    <= 1'b1;
            hold_left    <= 80;
            next_hold_at <= next_hold_at + 170;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_mode <= $urandom_range(0, 3);
                pattern_left <= $urandom_range(5, 60);
            end
            else
                pattern_left <= pattern_left - 1;
            pattern_tick <= ~pattern_tick;
            case (pattern_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= pattern_tick;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                rgb_expected.push_back(convert_colour(hue, saturation_in, level, active_model));
                void'(pending_colours.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (rgb_expected.size() == 0)
            begin
                $error("unexpected output word: red %0d green %0d blue %0d", red, green, blue);
                error_count <= error_count + 1;
            end
            else
            begin
                rgb_want = rgb_expected.pop_front();
                if (red !== rgb_want.red)
                    $error("red: expected %0d, got %0d", rgb_want.red, red);
                if (green !== rgb_want.green)
                    $error("green: expected %0d, got %0d", rgb_want.green, green);
                if (blue !== rgb_want.blue)
                    $error("blue: expected %0d, got %0d", rgb_want.blue, blue);
                if (red !== rgb_want.red || green !== rgb_want.green || blue !== rgb_want.blue)
                    error_count <= error_count + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("** hsv_hsl_to_rgb_unit: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic convert_phase(input colour_model_t model, input bit directed, input int count);
        logic [HUE_W-1:0]  h;
        logic [UNIT_W-1:0] s;
        logic [UNIT_W-1:0] l;
        int unsigned       kind;
        while (pending_colours.size() != 0 || rgb_expected.size() != 0)
            @(negedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= model;
        active_model  = model;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (directed)
        begin
            pending_colours.push_back('{15'd0,     13'd0,    13'd0});
            pending_colours.push_back('{15'd0,     13'd4096, 13'd4096});
            pending_colours.push_back('{15'd3840,  13'd4096, 13'd4096});
            pending_colours.push_back('{15'd7680,  13'd4096, 13'd4096});
            pending_colours.push_back('{15'd11520, 13'd4096, 13'd4096});
            pending_colours.push_back('{15'd15360, 13'd4096, 13'd4096});
            pending_colours.push_back('{15'd19200, 13'd4096, 13'd4096});
            pending_colours.push_back('{15'd23040, 13'd4096, 13'd2048});
            pending_colours.push_back('{15'd32767, 13'd8191, 13'd8191});
            pending_colours.push_back('{15'd1920,  13'd2048, 13'd2048});
            pending_colours.push_back('{15'd23039, 13'd4096, 13'd4095});
            pending_colours.push_back('{15'd5000,  13'd0,    13'd3000});
            pending_colours.push_back('{15'd12345, 13'd4097, 13'd0});
            pending_colours.push_back('{15'd960,   13'd3000, 13'd2600});
        end
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            h = HUE_W'($urandom_range(0, 32'(HUE_MAX)));
            s = UNIT_W'($urandom_range(0, 32'(UNIT_ONE)));
            l = UNIT_W'($urandom_range(0, 32'(UNIT_ONE)));
            case (kind)
                0:
                begin
                    h = HUE_W'($urandom);
                    s = UNIT_W'($urandom);
                    l = UNIT_W'($urandom);
                end
                1: h = HUE_W'($urandom_range(1, 6) * HUE_SIXTY - 1 + $urandom_range(0, 2));
                2:
                begin
                    s = $urandom_range(0, 1) ? UNIT_W'(UNIT_ONE) : '0;
                    l = $urandom_range(0, 1) ? UNIT_W'(UNIT_ONE) : '0;
                end
                3: l = UNIT_W'(UNIT_ONE / 2 - 2 + $urandom_range(0, 4));
                default:
                begin
                end
            endcase
            pending_colours.push_back('{h, s, l});
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        convert_phase(MODEL_HSV, 1'b1, 0);
        convert_phase(MODEL_HSL, 1'b1, 0);
        convert_phase(MODEL_HSL, 1'b0, 100);
        convert_phase(MODEL_HSV, 1'b0, 100);
        convert_phase(MODEL_HSL, 1'b0, 100);
        convert_phase(MODEL_HSV, 1'b0, 100);
        while (pending_colours.size() != 0 || rgb_expected.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        if (error_count == 0)
            $display("** hsv_hsl_to_rgb_unit: PASSED **");
        else
            $display("** hsv_hsl_to_rgb_unit: FAILED **");
        $finish;
    end

endmodule : hsv_hsl_to_rgb_unit_tb

`default_nettype wire

>>> filelist.f
rtl/hsvrgb_pkg.sv
rtl/hsv_hsl_to_rgb_unit.sv
tb/hsv_hsl_to_rgb_unit_tb.sv
